// ===== hw/rtl/mpsm_pkg.sv =====
// Package for the multi-pattern string matcher.
// Holds request, status and sequencer state codes and the fixed field widths.
// No dependencies.
`default_nettype none

package mpsm_pkg;

    localparam int REQ_W      = 3;
    localparam int SYM_IN_W   = 8;
    localparam int LEN_W      = 6;
    localparam int POS_W      = 32;
    localparam int STAT_W     = 2;
    localparam int RESULT_CAP = 32;
    localparam int CNT_W      = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR    = 3'd0,
        REQ_PAT_BYTE = 3'd1,
        REQ_PAT_END  = 3'd2,
        REQ_FINALIZE = 3'd3,
        REQ_TEXT     = 3'd4
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_TABLE_FULL = 2'd1,
        STAT_TOO_DEEP   = 2'd2,
        STAT_BAD_PHASE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SUF_WAIT,
        S_ADD,
        S_RESP,
        S_FIN_START,
        S_FIN_QRD,
        S_FIN_QWAIT,
        S_FIN_VRD,
        S_FIN_VCHK,
        S_FIN_SWAIT,
        S_FIN_LINK,
        S_FIN_LWAIT,
        S_EMIT_RD,
        S_EMIT_CHK
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mpsm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_pattern_string_matcher.sv =====
// Top level of the multi-pattern string matcher: trie build, link finalize and text scan.
// Depends on mpsm_pkg and mpsm_ram.
//
// Usage: each input item carries a request (clear, pattern byte, pattern end, finalize,
// text byte). Patterns are loaded byte by byte, each closed by a pattern end, then a
// finalize computes the suffix and output links, after which text bytes are matched.
// A text byte gives one result item per pattern ending at it (at most RESULT_CAP),
// deepest first, with last set on the final one, or a single no-match item. Every other
// request gives one item. One item is worked on at a time; s_ready is high only while
// the sequencer is idle. Child lookup is a linear scan of the node table, one stored
// node at a time. A text byte takes one scan per suffix link followed plus one depth
// read per result item. Finalize takes roughly one scan per node plus a read of each
// node and of each parent. All scans go through the single node table read port that
// the sequencer shares.
// The result register lets a new item be accepted while the last result still waits;
// when m_ready is low the sequencer holds in its emit step until the register frees.
// Reset empties the table (root only) and drops any pending result.
`default_nettype none

module multi_pattern_string_matcher #(
    parameter int MAX_NODES   = 256,
    parameter int MAX_DEPTH   = 32,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [mpsm_pkg::REQ_W-1:0]      s_req_type,
    input  wire logic [mpsm_pkg::SYM_IN_W-1:0]   s_symbol,
    input  wire logic                            s_text_start,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_match_valid,
    output logic      [mpsm_pkg::LEN_W-1:0]      m_match_length,
    output logic      [mpsm_pkg::POS_W-1:0]      m_end_position,
    output logic      [mpsm_pkg::STAT_W-1:0]     m_status,
    output logic                                 m_last
);

    import mpsm_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = NW + 1;
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int SB  = SYMBOL_BITS;
    localparam int SBX = (SB > SYM_IN_W) ? SB : SYM_IN_W;
    localparam logic [CW-1:0] NONE = CW'(MAX_NODES);

    state_t        state_reg, state_next;
    req_t          op_reg, op_next;
    status_t       status_reg, status_next;
    logic [CW-1:0] node_count_reg, node_count_next;
    logic [NW-1:0] build_cursor_reg, build_cursor_next;
    logic [DW-1:0] cur_depth_reg, cur_depth_next;
    logic          broken_reg, broken_next;
    logic          links_reg, links_next;
    logic [NW-1:0] mc_reg, mc_next;
    logic [POS_W-1:0] text_index_reg, text_index_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [NW-1:0] gn_node_reg, gn_node_next;
    logic [SB-1:0] gn_sym_reg, gn_sym_next;
    logic [CW-1:0] v_reg, v_next;
    logic [NW-1:0] u_reg, u_next;
    logic [CW-1:0] w_reg, w_next;
    logic [NW-1:0] s_reg, s_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic          first_reg, first_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_mv_reg;
    logic [LEN_W-1:0]  m_len_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic [STAT_W-1:0] m_stat_reg;
    logic          m_last_reg;

    logic [SBX-1:0] sym_x;
    logic [SB-1:0]  sym_in;
    logic           accept;
    logic           out_free;

    logic              ps_we, ps_re;
    logic [NW-1:0]     ps_wa, ps_ra;
    logic [NW+SB-1:0]  ps_wd, ps_rd;
    logic              da_we, da_re;
    logic [NW-1:0]     da_wa, da_ra;
    logic [DW:0]       da_wd, da_rd;
    logic              ou_we;
    logic [NW-1:0]     ou_wa;
    logic [CW-1:0]     ou_wd, ou_rd;
    logic              sf_we, sf_re;
    logic [NW-1:0]     sf_wa, sf_ra;
    logic [NW-1:0]     sf_wd, sf_rd;
    logic              q_we, q_re;
    logic [NW-1:0]     q_wa, q_ra;
    logic [NW-1:0]     q_wd, q_rd;

    logic              emit;
    logic              e_mv;
    logic [LEN_W-1:0]  e_len;
    logic [POS_W-1:0]  e_pos;
    logic [STAT_W-1:0] e_stat;
    logic              e_last;

    logic [NW-1:0] rd_parent;
    logic [SB-1:0] rd_sym;
    logic          hit;
    logic          node_acc;
    logic [CW-1:0] node_out;
    logic          out_ok;
    logic [NW-1:0] mc_start;
    logic [POS_W-1:0] ti_start;

    assign sym_x    = SBX'(s_symbol);
    assign sym_in   = sym_x[SB-1:0];
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign rd_parent = ps_rd[NW+SB-1:SB];
    assign rd_sym    = ps_rd[SB-1:0];
    assign hit       = (rd_parent == gn_node_reg) && (rd_sym == gn_sym_reg);

    // The root is never written: it is never accepting and has no output link.
    always_comb begin
        if (op_reg == REQ_FINALIZE) begin
            node_acc = (s_reg != '0) && da_rd[DW];
            node_out = (s_reg == '0) ? NONE : ou_rd;
        end else begin
            node_acc = (cur_reg != '0) && da_rd[DW];
            node_out = (cur_reg == '0) ? NONE : ou_rd;
        end
    end
    assign out_ok = (node_out < node_count_reg);

    assign mc_start = s_text_start ? '0 : mc_reg;
    assign ti_start = s_text_start ? '0 : text_index_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_PAT_BYTE: begin
                            if (!links_reg && !broken_reg && cur_depth_reg < DW'(MAX_DEPTH)) begin
                                state_next = S_SCAN_RD;
                            end else begin
                                state_next = S_RESP;
                            end
                        end
                        REQ_FINALIZE: state_next = S_FIN_START;
                        REQ_TEXT:     state_next = links_reg ? S_SCAN_RD : S_RESP;
                        default:      state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (v_reg >= node_count_reg) begin
                    if (op_reg == REQ_PAT_BYTE) begin
                        state_next = (node_count_reg >= NONE) ? S_RESP : S_ADD;
                    end else if (gn_node_reg != '0) begin
                        state_next = S_SUF_WAIT;
                    end else if (op_reg == REQ_FINALIZE) begin
                        state_next = S_FIN_LINK;
                    end else begin
                        state_next = S_EMIT_RD;
                    end
                end else begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!hit) begin
                    state_next = S_SCAN_RD;
                end else if (op_reg == REQ_PAT_BYTE) begin
                    state_next = S_RESP;
                end else if (op_reg == REQ_FINALIZE) begin
                    state_next = S_FIN_LINK;
                end else begin
                    state_next = S_EMIT_RD;
                end
            end
            S_SUF_WAIT:  state_next = S_SCAN_RD;
            S_ADD:       state_next = S_RESP;
            S_RESP:      state_next = out_free ? S_IDLE : S_RESP;
            S_FIN_START: state_next = S_FIN_QRD;
            S_FIN_QRD:   state_next = (head_reg >= tail_reg) ? S_RESP : S_FIN_QWAIT;
            S_FIN_QWAIT: state_next = S_FIN_VRD;
            S_FIN_VRD:   state_next = (w_reg >= node_count_reg) ? S_FIN_QRD : S_FIN_VCHK;
            S_FIN_VCHK: begin
                if (rd_parent != u_reg) begin
                    state_next = S_FIN_VRD;
                end else if (u_reg == '0) begin
                    state_next = S_FIN_LINK;
                end else begin
                    state_next = S_FIN_SWAIT;
                end
            end
            S_FIN_SWAIT: state_next = S_SCAN_RD;
            S_FIN_LINK:  state_next = S_FIN_LWAIT;
            S_FIN_LWAIT: state_next = S_FIN_VRD;
            S_EMIT_RD:   state_next = S_EMIT_CHK;
            S_EMIT_CHK: begin
                if (out_free) begin
                    if (out_ok && (!(first_reg && !node_acc) ? (n_reg < CNT_W'(RESULT_CAP - 1)) : 1'b1)) begin
                        state_next = S_EMIT_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        op_next           = op_reg;
        status_next       = status_reg;
        node_count_next   = node_count_reg;
        build_cursor_next = build_cursor_reg;
        cur_depth_next    = cur_depth_reg;
        broken_next       = broken_reg;
        links_next        = links_reg;
        mc_next           = mc_reg;
        text_index_next   = text_index_reg;
        pos_next          = pos_reg;
        gn_node_next      = gn_node_reg;
        gn_sym_next       = gn_sym_reg;
        v_next            = v_reg;
        u_next            = u_reg;
        w_next            = w_reg;
        s_next            = s_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        cur_next          = cur_reg;
        first_next        = first_reg;
        n_next            = n_reg;

        ps_we = 1'b0; ps_wa = node_count_reg[NW-1:0]; ps_wd = {build_cursor_reg, gn_sym_reg};
        ps_re = 1'b0; ps_ra = v_reg[NW-1:0];
        da_we = 1'b0; da_wa = node_count_reg[NW-1:0]; da_wd = {1'b0, cur_depth_reg + 1'b1};
        da_re = 1'b0; da_ra = cur_reg;
        ou_we = 1'b0; ou_wa = node_count_reg[NW-1:0]; ou_wd = NONE;
        sf_we = 1'b0; sf_wa = node_count_reg[NW-1:0]; sf_wd = '0;
        sf_re = 1'b0; sf_ra = gn_node_reg;
        q_we  = 1'b0; q_wa  = tail_reg[NW-1:0]; q_wd = w_reg[NW-1:0];
        q_re  = 1'b0; q_ra  = head_reg[NW-1:0];

        emit   = 1'b0;
        e_mv   = 1'b0;
        e_len  = '0;
        e_pos  = '0;
        e_stat = status_reg;
        e_last = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next     = req_t'(s_req_type);
                    status_next = STAT_OK;
                    gn_sym_next = sym_in;
                    v_next      = CW'(1);
                    case (s_req_type)
                        REQ_CLEAR: begin
                            node_count_next   = CW'(1);
                            build_cursor_next = '0;
                            cur_depth_next    = '0;
                            broken_next       = 1'b0;
                            links_next        = 1'b0;
                            mc_next           = '0;
                            text_index_next   = '0;
                        end
                        REQ_PAT_BYTE: begin
                            gn_node_next = build_cursor_reg;
                            if (links_reg) begin
                                status_next = STAT_BAD_PHASE;
                            end else if (!broken_reg && cur_depth_reg >= DW'(MAX_DEPTH)) begin
                                status_next = STAT_TOO_DEEP;
                                broken_next = 1'b1;
                            end
                        end
                        REQ_PAT_END: begin
                            if (links_reg) begin
                                status_next = STAT_BAD_PHASE;
                            end else begin
                                if (!broken_reg && build_cursor_reg != '0) begin
                                    da_we = 1'b1;
                                    da_wa = build_cursor_reg;
                                    da_wd = {1'b1, cur_depth_reg};
                                end
                                build_cursor_next = '0;
                                cur_depth_next    = '0;
                                broken_next       = 1'b0;
                            end
                        end
                        REQ_FINALIZE: begin
                        end
                        REQ_TEXT: begin
                            if (!links_reg) begin
                                status_next = STAT_BAD_PHASE;
                            end else begin
                                gn_node_next    = ({1'b0, mc_start} >= node_count_reg) ? '0
                                                                                      : mc_start;
                                pos_next        = ti_start;
                                text_index_next = ti_start + 1'b1;
                            end
                        end
                        default: status_next = STAT_BAD_PHASE;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (v_reg >= node_count_reg) begin
                    if (op_reg == REQ_PAT_BYTE) begin
                        if (node_count_reg >= NONE) begin
                            status_next = STAT_TABLE_FULL;
                            broken_next = 1'b1;
                        end
                    end else if (gn_node_reg != '0) begin
                        sf_re = 1'b1;
                    end else begin
                        s_next     = '0;
                        mc_next    = (op_reg == REQ_TEXT) ? '0 : mc_reg;
                        cur_next   = '0;
                        first_next = 1'b1;
                        n_next     = '0;
                    end
                end else begin
                    ps_re = 1'b1;
                end
            end
            S_SCAN_CHK: begin
                if (!hit) begin
                    v_next = v_reg + 1'b1;
                end else begin
                    build_cursor_next = (op_reg == REQ_PAT_BYTE) ? v_reg[NW-1:0]
                                                                 : build_cursor_reg;
                    cur_depth_next    = (op_reg == REQ_PAT_BYTE) ? cur_depth_reg + 1'b1
                                                                 : cur_depth_reg;
                    s_next     = v_reg[NW-1:0];
                    mc_next    = (op_reg == REQ_TEXT) ? v_reg[NW-1:0] : mc_reg;
                    cur_next   = v_reg[NW-1:0];
                    first_next = 1'b1;
                    n_next     = '0;
                end
            end
            S_SUF_WAIT: begin
                gn_node_next = sf_rd;
                v_next       = CW'(1);
            end
            S_ADD: begin
                ps_we = 1'b1;
                da_we = 1'b1;
                ou_we = 1'b1;
                sf_we = 1'b1;
                build_cursor_next = node_count_reg[NW-1:0];
                node_count_next   = node_count_reg + 1'b1;
                cur_depth_next    = cur_depth_reg + 1'b1;
            end
            S_RESP: begin
                emit = out_free;
            end
            S_FIN_START: begin
                q_we      = 1'b1;
                q_wa      = '0;
                q_wd      = '0;
                head_next = '0;
                tail_next = CW'(1);
            end
            S_FIN_QRD: begin
                if (head_reg >= tail_reg) begin
                    links_next = 1'b1;
                end else begin
                    q_re      = 1'b1;
                    head_next = head_reg + 1'b1;
                end
            end
            S_FIN_QWAIT: begin
                u_next = q_rd;
                w_next = CW'(1);
            end
            S_FIN_VRD: begin
                ps_ra = w_reg[NW-1:0];
                ps_re = (w_reg < node_count_reg);
            end
            S_FIN_VCHK: begin
                if (rd_parent != u_reg) begin
                    w_next = w_reg + 1'b1;
                end else if (u_reg == '0) begin
                    s_next = '0;
                end else begin
                    gn_sym_next = rd_sym;
                    sf_re       = 1'b1;
                    sf_ra       = u_reg;
                end
            end
            S_FIN_SWAIT: begin
                gn_node_next = sf_rd;
                v_next       = CW'(1);
            end
            S_FIN_LINK: begin
                da_re = 1'b1;
                da_ra = s_reg;
            end
            S_FIN_LWAIT: begin
                sf_we = 1'b1;
                sf_wa = w_reg[NW-1:0];
                sf_wd = s_reg;
                ou_we = 1'b1;
                ou_wa = w_reg[NW-1:0];
                ou_wd = node_acc ? {1'b0, s_reg} : node_out;
                if (tail_reg < NONE) begin
                    q_we      = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                w_next = w_reg + 1'b1;
            end
            S_EMIT_RD: begin
                da_re = 1'b1;
            end
            S_EMIT_CHK: begin
                if (out_free) begin
                    if (!first_reg || node_acc) begin
                        emit   = 1'b1;
                        e_mv   = 1'b1;
                        e_len  = LEN_W'(da_rd[DW-1:0]);
                        e_pos  = pos_reg;
                        e_stat = STAT_OK;
                        e_last = !(out_ok && n_reg < CNT_W'(RESULT_CAP - 1));
                        n_next = n_reg + 1'b1;
                    end else if (!out_ok) begin
                        emit   = 1'b1;
                        e_pos  = pos_reg;
                        e_stat = STAT_OK;
                    end
                    first_next = 1'b0;
                    cur_next   = node_out[NW-1:0];
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // The output link read shares the address of the depth and accept read.
    mpsm_ram #(.WIDTH(NW + SB), .DEPTH(MAX_NODES)) u_ps_ram (
        .aclk(aclk), .wr_en(ps_we), .wr_addr(ps_wa), .wr_data(ps_wd),
        .rd_en(ps_re), .rd_addr(ps_ra), .rd_data(ps_rd)
    );

    mpsm_ram #(.WIDTH(DW + 1), .DEPTH(MAX_NODES)) u_da_ram (
        .aclk(aclk), .wr_en(da_we), .wr_addr(da_wa), .wr_data(da_wd),
        .rd_en(da_re), .rd_addr(da_ra), .rd_data(da_rd)
    );

    mpsm_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_out_ram (
        .aclk(aclk), .wr_en(ou_we), .wr_addr(ou_wa), .wr_data(ou_wd),
        .rd_en(da_re), .rd_addr(da_ra), .rd_data(ou_rd)
    );

    mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_suf_ram (
        .aclk(aclk), .wr_en(sf_we), .wr_addr(sf_wa), .wr_data(sf_wd),
        .rd_en(sf_re), .rd_addr(sf_ra), .rd_data(sf_rd)
    );

    mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_q_ram (
        .aclk(aclk), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
        .rd_en(q_re), .rd_addr(q_ra), .rd_data(q_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            node_count_reg   <= CW'(1);
            build_cursor_reg <= '0;
            cur_depth_reg    <= '0;
            broken_reg       <= 1'b0;
            links_reg        <= 1'b0;
            mc_reg           <= '0;
            text_index_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            node_count_reg   <= node_count_next;
            build_cursor_reg <= build_cursor_next;
            cur_depth_reg    <= cur_depth_next;
            broken_reg       <= broken_next;
            links_reg        <= links_next;
            mc_reg           <= mc_next;
            text_index_reg   <= text_index_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        gn_node_reg <= gn_node_next;
        gn_sym_reg  <= gn_sym_next;
        v_reg       <= v_next;
        u_reg       <= u_next;
        w_reg       <= w_next;
        s_reg       <= s_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        cur_reg     <= cur_next;
        first_reg   <= first_next;
        n_reg       <= n_next;
        if (emit) begin
            m_mv_reg   <= e_mv;
            m_len_reg  <= e_len;
            m_pos_reg  <= e_pos;
            m_stat_reg <= e_stat;
            m_last_reg <= e_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_match_valid  = m_mv_reg;
    assign m_match_length = m_len_reg;
    assign m_end_position = m_pos_reg;
    assign m_status       = m_stat_reg;
    assign m_last         = m_last_reg;

    a_node_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        node_count_reg >= CW'(1) && node_count_reg <= NONE)
        else $error("node count out of range");

    a_match_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_match_valid |-> m_match_length != '0 && m_status == STAT_OK)
        else $error("match item without length or with error status");

    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item did not start the sequencer");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result register overwritten while held");

endmodule

`default_nettype wire
